FILE: sv/hprd_pkg.sv
package hprd_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int REG_WIDTH    = 16;
  localparam int TIME_WIDTH   = 32;
  localparam int BPM_WIDTH    = 16;
  localparam int CFG_IDX_WIDTH = 2;

  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_WIDTH   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_WIDTH   = $clog2(QUEUE_DEPTH + 1);

  localparam int DIV_CNT_WIDTH = $clog2(BPM_WIDTH);

  localparam logic signed [REG_WIDTH-1:0] THRESHOLD_RESET = 16'sd2000;
  localparam logic [REG_WIDTH-1:0]        SPACING_RESET   = 16'd600;
  localparam logic [BPM_WIDTH-1:0]        MS_PER_MINUTE   = 16'd60000;

  localparam logic [CFG_IDX_WIDTH-1:0] REG_PEAK_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_MIN_SPACING    = 2'd1;

  typedef struct packed {
    logic                  valid;
    logic [TIME_WIDTH-1:0] interval;
  } q_push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_DONE = 3'b100
  } div_state_e;

endpackage

FILE: sv/hprd_front.sv
module hprd_front (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [hprd_pkg::CFG_IDX_WIDTH-1:0]    cfg_index_i,
  input  logic [hprd_pkg::REG_WIDTH-1:0]        cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [hprd_pkg::SAMPLE_WIDTH-1:0] sample_i,
  input  logic [hprd_pkg::TIME_WIDTH-1:0]       timestamp_ms_i,
  input  hprd_pkg::q_status_t                   q_status_i,
  output hprd_pkg::q_push_t                     q_push_o
);
  import hprd_pkg::*;

  logic signed [REG_WIDTH-1:0] threshold_q, threshold_d;
  logic [REG_WIDTH-1:0]        spacing_q, spacing_d;
  logic [TIME_WIDTH-1:0]       last_beat_q, last_beat_d;

  logic signed [REG_WIDTH-1:0] sample_ext;
  logic [TIME_WIDTH-1:0]       elapsed;
  logic                        accept;
  logic                        beat;

  assign sample_ext = REG_WIDTH'(signed'(sample_i));
  assign elapsed    = timestamp_ms_i - last_beat_q;
  assign beat       = (sample_ext > threshold_q) &&
                      (elapsed > TIME_WIDTH'(spacing_q));
  assign in_stall_o = q_status_i.full;
  assign accept     = in_valid_i && !in_stall_o;

  assign q_push_o.valid    = accept && beat;
  assign q_push_o.interval = elapsed;

  always_comb begin
    threshold_d = threshold_q;
    spacing_d   = spacing_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_PEAK_THRESHOLD: threshold_d = cfg_data_i;
        REG_MIN_SPACING:    spacing_d   = cfg_data_i;
        default: ;
      endcase
    end
  end

  assign last_beat_d = q_push_o.valid ? timestamp_ms_i : last_beat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= THRESHOLD_RESET;
      spacing_q   <= SPACING_RESET;
      last_beat_q <= '0;
    end else begin
      threshold_q <= threshold_d;
      spacing_q   <= spacing_d;
      last_beat_q <= last_beat_d;
    end
  end

endmodule

FILE: sv/hprd_queue.sv
module hprd_queue (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  hprd_pkg::q_push_t               push_i,
  input  logic                            pop_i,
  output logic [hprd_pkg::TIME_WIDTH-1:0] rd_data_o,
  output hprd_pkg::q_status_t             status_o
);
  import hprd_pkg::*;

  logic [TIME_WIDTH-1:0] entry_q [QUEUE_DEPTH];
  logic [QPTR_WIDTH-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_WIDTH-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_WIDTH-1:0] count_q, count_d;
  logic                  do_push, do_pop;

  assign status_o.full  = (count_q == QCNT_WIDTH'(QUEUE_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign do_push = push_i.valid && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign rd_data_o = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_i.interval;
    end
  end

endmodule

FILE: sv/hprd_back.sv
module hprd_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  hprd_pkg::q_status_t             q_status_i,
  input  logic [hprd_pkg::TIME_WIDTH-1:0] q_data_i,
  output logic                            q_pop_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [hprd_pkg::BPM_WIDTH-1:0]  beats_per_minute_o,
  output logic [hprd_pkg::TIME_WIDTH-1:0] beat_interval_ms_o
);
  import hprd_pkg::*;

  div_state_e               state_q, state_d;
  logic [DIV_CNT_WIDTH-1:0] cnt_q, cnt_d;
  logic [TIME_WIDTH-1:0]    divisor_q, divisor_d;
  logic [BPM_WIDTH-1:0]     dvd_q, dvd_d;
  logic [BPM_WIDTH-1:0]     rem_q, rem_d;
  logic [BPM_WIDTH-1:0]     quo_q, quo_d;
  logic                     out_valid_q, out_valid_d;
  logic [BPM_WIDTH-1:0]     bpm_q, bpm_d;
  logic [TIME_WIDTH-1:0]    interval_q, interval_d;

  logic [BPM_WIDTH:0]       trial;
  logic [BPM_WIDTH:0]       trial_sub;
  logic                     fits;
  logic                     out_free;

  // restoring division; remainder never exceeds the dividend so it stays narrow
  assign trial     = {rem_q, dvd_q[BPM_WIDTH-1]};
  assign fits      = TIME_WIDTH'(trial) >= divisor_q;
  assign trial_sub = trial - divisor_q[BPM_WIDTH:0];
  assign out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    divisor_d   = divisor_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    out_valid_d = out_valid_q && out_stall_i;
    bpm_d       = bpm_q;
    interval_d  = interval_q;
    q_pop_o     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (!q_status_i.empty) begin
          q_pop_o   = 1'b1;
          divisor_d = q_data_i;
          dvd_d     = MS_PER_MINUTE;
          rem_d     = '0;
          quo_d     = '0;
          cnt_d     = '0;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        rem_d = fits ? trial_sub[BPM_WIDTH-1:0] : trial[BPM_WIDTH-1:0];
        quo_d = {quo_q[BPM_WIDTH-2:0], fits};
        dvd_d = {dvd_q[BPM_WIDTH-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_WIDTH'(BPM_WIDTH - 1)) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          bpm_d       = quo_q;
          interval_d  = divisor_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    divisor_q  <= divisor_d;
    dvd_q      <= dvd_d;
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    bpm_q      <= bpm_d;
    interval_q <= interval_d;
  end

  assign out_valid_o        = out_valid_q;
  assign beats_per_minute_o = bpm_q;
  assign beat_interval_ms_o = interval_q;

endmodule

FILE: sv/heartbeat_peak_rate_detector.sv
// Heartbeat peak detector with beat-rate output.
// Input channel: in_valid_i / in_stall_o carry one sample and its millisecond
// timestamp per transaction. A beat is a sample above the threshold arriving
// more than the minimum spacing after the previous beat (mod 2^32 time).
// Output channel: out_valid_o / out_stall_i carry one transaction per beat:
// the interval since the previous beat and 60000 / interval, truncated.
// Samples that are not beats produce nothing.
// Config: cfg_we_i writes cfg_data_i to register cfg_index_i
// (0 = peak threshold, 1 = minimum spacing); write only while idle.
// The front classifies and accepts a sample every cycle as long as the
// two-entry beat queue has room; stall is the queue being full.
// An accepted beat passes through the queue and the 16-step radix-2 divider
// in the back end before reaching out_valid_o; the divider works on one beat
// at a time; non-beat samples pass at one per cycle while the queue has room.
// Reset clears the last beat time to zero (the first interval is measured
// from time zero), restores register defaults and empties the queue.
// A stalled result holds in the output register; the divider finishes the
// next beat behind it and the queue then backs up into in_stall_o.
module heartbeat_peak_rate_detector (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     cfg_we_i,
  input  logic [hprd_pkg::CFG_IDX_WIDTH-1:0]       cfg_index_i,
  input  logic [hprd_pkg::REG_WIDTH-1:0]           cfg_data_i,
  input  logic                                     in_valid_i,
  output logic                                     in_stall_o,
  input  logic signed [hprd_pkg::SAMPLE_WIDTH-1:0] sample_i,
  input  logic [hprd_pkg::TIME_WIDTH-1:0]          timestamp_ms_i,
  output logic                                     out_valid_o,
  input  logic                                     out_stall_i,
  output logic [hprd_pkg::BPM_WIDTH-1:0]           beats_per_minute_o,
  output logic [hprd_pkg::TIME_WIDTH-1:0]          beat_interval_ms_o
);
  import hprd_pkg::*;

  q_push_t               q_push;
  q_status_t             q_status;
  logic                  q_pop;
  logic [TIME_WIDTH-1:0] q_data;

  hprd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sample_i       (sample_i),
    .timestamp_ms_i (timestamp_ms_i),
    .q_status_i     (q_status),
    .q_push_o       (q_push)
  );

  hprd_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (q_push),
    .pop_i     (q_pop),
    .rd_data_o (q_data),
    .status_o  (q_status)
  );

  hprd_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .q_status_i         (q_status),
    .q_data_i           (q_data),
    .q_pop_o            (q_pop),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .beats_per_minute_o (beats_per_minute_o),
    .beat_interval_ms_o (beat_interval_ms_o)
  );

endmodule

FILE: sv/hprd_checker.sv
module hprd_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic [hprd_pkg::BPM_WIDTH-1:0]  beats_per_minute_o,
  input logic [hprd_pkg::TIME_WIDTH-1:0] beat_interval_ms_o
);
  import hprd_pkg::*;

  // held result must not change under stall
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o &&
      $stable(beats_per_minute_o) && $stable(beat_interval_ms_o))
    else $error("stalled result changed");

  a_interval_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> beat_interval_ms_o != '0)
    else $error("zero beat interval");

  a_slow_rate_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (beat_interval_ms_o > TIME_WIDTH'(MS_PER_MINUTE))
      |-> beats_per_minute_o == '0)
    else $error("nonzero rate for interval above one minute");

  a_unit_interval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (beat_interval_ms_o == TIME_WIDTH'(1))
      |-> beats_per_minute_o == MS_PER_MINUTE)
    else $error("wrong rate for one millisecond interval");

  a_reset_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid straight out of reset");

endmodule

bind heartbeat_peak_rate_detector hprd_checker u_hprd_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .beats_per_minute_o (beats_per_minute_o),
  .beat_interval_ms_o (beat_interval_ms_o)
);
